@@ hdl/llrb_pkg.sv @@
// Shared constants and types for the last-lines ring buffer.
package llrb_pkg;

   localparam int DEF_MAX_LINES       = 16;
   localparam int DEF_MAX_LINE_LENGTH = 4095;
   localparam int LINE_COUNT_W        = 5;
   localparam int REQ_DATA_W          = 8;
   localparam int RSP_DATA_W          = 16;

   localparam logic [7:0]              NEWLINE          = 8'd10;
   localparam logic [LINE_COUNT_W-1:0] LINE_COUNT_RESET = 5'd10;

   typedef enum logic [1:0] {
      CMD_PUSH    = 2'd0,
      CMD_END     = 2'd1,
      CMD_READ    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

endpackage

@@ hdl/last_lines_ring_buffer.sv @@
// Last-lines ring buffer: keeps the most recent complete lines of a byte stream.
//
// Usage:
//   Each request word on req_ carries a command in req_tuser (push byte, end of
//   stream, read next byte, restart empty) and a stream byte in req_tdata.
//   Every accepted word yields exactly one response word on rsp_: the byte read
//   (zero unless a read hit a stored byte), a flag for that in rsp_tuser, the
//   final drained byte marked by rsp_tlast, the sticky truncation flag and the
//   number of lines held.
//   Throughput is one word per cycle for every command while rsp_tready stays
//   high: a push writes one location of the line memory and a read fetches
//   one, through a single memory port each.
//   A response passes from acceptance through the registered memory read and
//   then the output register.
//   When rsp_tready is low the response holds; one more request is still taken
//   into the read stage, after which req_tready drops until the output drains.
//   csr_write_enable loads line_count and empties the buffer; write it only
//   while no response is outstanding.
//   Reset empties the buffer and sets line_count to 10. The line memory is not
//   cleared; no stored byte is read before it is written.
module last_lines_ring_buffer #(
   parameter int MAX_LINES       = llrb_pkg::DEF_MAX_LINES,
   parameter int MAX_LINE_LENGTH = llrb_pkg::DEF_MAX_LINE_LENGTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [llrb_pkg::LINE_COUNT_W-1:0] csr_write_data,    // [4:0] line_count
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [llrb_pkg::REQ_DATA_W-1:0]   req_tdata,         // [7:0] data_byte
   input  logic [1:0]                        req_tuser,         // [1:0] command
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [llrb_pkg::RSP_DATA_W-1:0]   rsp_tdata,         // [7:0] out_byte,
                                                                // [8] truncated,
                                                                // [13:9] stored_lines,
                                                                // [15:14] zero
   output logic                              rsp_tuser,         // [0] out_valid
   output logic                              rsp_tlast          // out_last
);

   import llrb_pkg::*;

   localparam int SW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int CW    = $clog2(MAX_LINES + 1);
   localparam int PW    = (MAX_LINE_LENGTH > 1) ? $clog2(MAX_LINE_LENGTH + 1) : 1;
   localparam int LW    = $clog2(MAX_LINE_LENGTH + 2);
   localparam int AW    = SW + PW;
   localparam int DEPTH = MAX_LINES * (2 ** PW);

   localparam logic [PW-1:0] MAX_POS   = PW'(MAX_LINE_LENGTH);
   localparam logic [LW-1:0] STRIDE_LW = LW'(MAX_LINE_LENGTH + 1);

   // state
   logic [LINE_COUNT_W-1:0] line_count_ff, line_count_in;
   logic [SW-1:0]           oldest_ff, oldest_in;
   logic [CW-1:0]           held_ff, held_in;
   logic [PW-1:0]           fill_ff, fill_in;
   logic                    discard_ff, discard_in;
   logic                    overlong_ff, overlong_in;
   logic                    drain_ff, drain_in;
   logic [PW-1:0]           rpos_ff, rpos_in;
   logic [LW-1:0]           slot_len_ff [MAX_LINES];

   // read stage and output register
   logic                    s1_valid_ff;
   logic                    s1_ov_ff, s1_ol_ff, s1_trunc_ff;
   logic [LINE_COUNT_W-1:0] s1_stored_ff;
   logic [7:0]              rdata_ff;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic                    rsp_user_ff, rsp_last_ff;

   logic [7:0] mem [DEPTH];

   logic          accept, s1_advance;
   cmd_type       cmd;
   logic [7:0]    in_byte;
   logic [CW-1:0] cap;
   logic          cap_zero;
   logic [CW:0]   wsum;
   logic [SW-1:0] wslot;
   logic [CW-1:0] oldest_plus;
   logic [SW-1:0] oldest_wrap;
   logic [LW-1:0] rpos_next;
   logic          mem_we;
   logic [PW-1:0] wpos;
   logic [7:0]    wdata;
   logic          len_we;
   logic [LW-1:0] len_wdata;
   logic          commit;
   logic          rd_hit, rd_last;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign in_byte    = req_tdata;

   always_comb begin
      if (32'(line_count_ff) > 32'(MAX_LINES)) begin
         cap = CW'(MAX_LINES);
      end else begin
         cap = CW'(line_count_ff);
      end
      cap_zero = (cap == '0);
      wsum = (CW+1)'(oldest_ff) + (CW+1)'(held_ff);
      if (wsum >= (CW+1)'(cap)) begin
         wsum = wsum - (CW+1)'(cap);
      end
      wslot       = SW'(wsum);
      oldest_plus = CW'(oldest_ff) + CW'(1);
      oldest_wrap = (oldest_plus == cap) ? '0 : SW'(oldest_plus);
      rpos_next   = LW'(rpos_ff) + LW'(1);
   end

   always_comb begin
      line_count_in = line_count_ff;
      oldest_in     = oldest_ff;
      held_in       = held_ff;
      fill_in       = fill_ff;
      discard_in    = discard_ff;
      overlong_in   = overlong_ff;
      drain_in      = drain_ff;
      rpos_in       = rpos_ff;
      mem_we        = 1'b0;
      wpos          = fill_ff;
      wdata         = NEWLINE;
      len_wdata     = LW'(fill_ff);
      commit        = 1'b0;
      rd_hit        = 1'b0;
      rd_last       = 1'b0;
      if (accept) begin
         unique case (cmd)
            CMD_PUSH: begin
               if (!drain_ff && !cap_zero) begin
                  if (in_byte == NEWLINE) begin
                     mem_we = 1'b1;
                     commit = 1'b1;
                     if (discard_ff) begin
                        wpos      = MAX_POS;
                        len_wdata = STRIDE_LW;
                     end else begin
                        len_wdata = LW'(fill_ff) + LW'(1);
                     end
                  end else if (!discard_ff) begin
                     if (fill_ff < MAX_POS) begin
                        mem_we  = 1'b1;
                        wdata   = in_byte;
                        fill_in = fill_ff + PW'(1);
                     end else begin
                        discard_in  = 1'b1;
                        overlong_in = 1'b1;
                     end
                  end
               end
            end
            CMD_END: begin
               if (!drain_ff) begin
                  if (!cap_zero) begin
                     if (discard_ff) begin
                        mem_we    = 1'b1;
                        commit    = 1'b1;
                        wpos      = MAX_POS;
                        len_wdata = STRIDE_LW;
                     end else if (fill_ff != '0) begin
                        commit = 1'b1;
                     end
                  end
                  drain_in = 1'b1;
                  rpos_in  = '0;
               end
            end
            CMD_READ: begin
               if (drain_ff && held_ff != '0 && !cap_zero) begin
                  rd_hit  = 1'b1;
                  rpos_in = PW'(rpos_next);
                  if (rpos_next >= slot_len_ff[oldest_ff] || rpos_next >= STRIDE_LW) begin
                     rpos_in   = '0;
                     oldest_in = oldest_wrap;
                     held_in   = held_ff - CW'(1);
                  end
                  rd_last = (held_in == '0);
               end
            end
            CMD_RESTART: begin
               oldest_in   = '0;
               held_in     = '0;
               fill_in     = '0;
               discard_in  = 1'b0;
               overlong_in = 1'b0;
               drain_in    = 1'b0;
               rpos_in     = '0;
            end
            default: begin
            end
         endcase
         if (commit) begin
            if (held_ff >= cap) begin
               oldest_in = oldest_wrap;
            end else begin
               held_in = held_ff + CW'(1);
            end
            fill_in    = '0;
            discard_in = 1'b0;
         end
      end
      if (csr_write_enable) begin
         line_count_in = csr_write_data;
         oldest_in     = '0;
         held_in       = '0;
         fill_in       = '0;
         discard_in    = 1'b0;
         overlong_in   = 1'b0;
         drain_in      = 1'b0;
         rpos_in       = '0;
      end
      len_we = commit && !csr_write_enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= LINE_COUNT_RESET;
         oldest_ff     <= '0;
         held_ff       <= '0;
         fill_ff       <= '0;
         discard_ff    <= 1'b0;
         overlong_ff   <= 1'b0;
         drain_ff      <= 1'b0;
         rpos_ff       <= '0;
      end else begin
         line_count_ff <= line_count_in;
         oldest_ff     <= oldest_in;
         held_ff       <= held_in;
         fill_ff       <= fill_in;
         discard_ff    <= discard_in;
         overlong_ff   <= overlong_in;
         drain_ff      <= drain_in;
         rpos_ff       <= rpos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         slot_len_ff[wslot] <= len_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we && !csr_write_enable) begin
         mem[{wslot, wpos}] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff <= mem[AW'({oldest_ff, rpos_ff})];
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ov_ff     <= rd_hit;
         s1_ol_ff     <= rd_last;
         s1_trunc_ff  <= overlong_in;
         s1_stored_ff <= LINE_COUNT_W'(held_in);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= {2'b00, s1_stored_ff, s1_trunc_ff, s1_ov_ff ? rdata_ff : 8'd0};
         rsp_user_ff <= s1_ov_ff;
         rsp_last_ff <= s1_ol_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   held_within_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap)
      else $error("held line count exceeds capacity");

   oldest_within_cap: assert property (@(posedge clock) disable iff (reset)
      (cap_zero && oldest_ff == '0) || (!cap_zero && CW'(oldest_ff) < cap))
      else $error("oldest slot outside ring");

   discard_at_full_line: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (fill_ff == MAX_POS))
      else $error("discarding before line is full");

   last_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("last flag without a stored byte");

   empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("request stalled with empty read stage");
`endif

endmodule

@@ tb/sv/llrb_checker.sv @@
// Stream checker for the last-lines ring buffer: predicts every response word and compares.
`timescale 1ns / 1ps
module llrb_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [llrb_pkg::LINE_COUNT_W-1:0] csr_write_data,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [llrb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [1:0]                        req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [llrb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tuser,
   input  logic                              rsp_tlast,
   output int                                words_due,
   output int                                mismatches
);

   import llrb_pkg::*;

   localparam int SLOT_BYTES = DEF_MAX_LINE_LENGTH + 1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic       truncated;
      logic [4:0] stored_lines;
   } tail_word_type;

   logic [7:0]              line_mem [0:DEF_MAX_LINES*SLOT_BYTES-1];
   int                      slot_len [0:DEF_MAX_LINES-1];
   int                      oldest_slot;
   int                      held_lines;
   int                      fill_pos;
   int                      read_pos;
   bit                      dropping;
   bit                      truncated_seen;
   bit                      draining;
   logic [LINE_COUNT_W-1:0] line_count;
   tail_word_type           tail_words_due[$];
   int                      due_count = 0;
   int                      fail_total = 0;

   assign words_due  = due_count;
   assign mismatches = fail_total;

   function automatic void empty_tail();
      oldest_slot    = 0;
      held_lines     = 0;
      fill_pos       = 0;
      read_pos       = 0;
      dropping       = 1'b0;
      truncated_seen = 1'b0;
      draining       = 1'b0;
   endfunction

   function automatic int kept_lines();
      return (int'(line_count) > DEF_MAX_LINES) ? DEF_MAX_LINES : int'(line_count);
   endfunction

   function automatic int fill_slot(int cap);
      return (oldest_slot + held_lines) % cap;
   endfunction

   function automatic void close_line(int cap, int len);
      slot_len[fill_slot(cap)] = len;
      if (held_lines >= cap) begin
         oldest_slot = (oldest_slot + 1) % cap;
      end else begin
         held_lines++;
      end
      fill_pos = 0;
      dropping = 1'b0;
   endfunction

   function automatic void close_truncated(int cap);
      line_mem[fill_slot(cap)*SLOT_BYTES + DEF_MAX_LINE_LENGTH] = NEWLINE;
      close_line(cap, SLOT_BYTES);
   endfunction

   function automatic tail_word_type predict_tail(cmd_type cmd, logic [7:0] b);
      tail_word_type w;
      int            cap;
      int            s;
      cap = kept_lines();
      w   = '0;
      case (cmd)
         CMD_PUSH: begin
            if (!draining && cap != 0) begin
               if (b == NEWLINE) begin
                  if (dropping) begin
                     close_truncated(cap);
                  end else begin
                     line_mem[fill_slot(cap)*SLOT_BYTES + fill_pos] = b;
                     close_line(cap, fill_pos + 1);
                  end
               end else if (!dropping) begin
                  if (fill_pos < DEF_MAX_LINE_LENGTH) begin
                     line_mem[fill_slot(cap)*SLOT_BYTES + fill_pos] = b;
                     fill_pos++;
                  end else begin
                     dropping       = 1'b1;
                     truncated_seen = 1'b1;
                  end
               end
            end
         end
         CMD_END: begin
            if (!draining) begin
               if (cap != 0) begin
                  if (dropping) begin
                     close_truncated(cap);
                  end else if (fill_pos > 0) begin
                     close_line(cap, fill_pos);
                  end
               end
               draining = 1'b1;
               read_pos = 0;
            end
         end
         CMD_READ: begin
            if (draining && held_lines > 0 && cap != 0) begin
               s           = oldest_slot % cap;
               w.out_byte  = line_mem[s*SLOT_BYTES + read_pos];
               w.out_valid = 1'b1;
               read_pos++;
               if (read_pos >= slot_len[s] || read_pos >= SLOT_BYTES) begin
                  read_pos    = 0;
                  oldest_slot = (s + 1) % cap;
                  held_lines--;
               end
               w.out_last = (held_lines == 0);
            end
         end
         default: begin
            empty_tail();
         end
      endcase
      w.truncated    = truncated_seen;
      w.stored_lines = held_lines[4:0];
      return w;
   endfunction

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      tail_word_type want;
      if (reset) begin
         line_count = LINE_COUNT_RESET;
         empty_tail();
         tail_words_due.delete();
      end else begin
         if (csr_write_enable) begin
            line_count = csr_write_data;
            empty_tail();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (tail_words_due.size() == 0) begin
               $display("%0t: response word mismatch, expected none actual %0h", $time,
                        rsp_tdata);
               fail_total++;
            end else begin
               want = tail_words_due.pop_front();
               compare_field("out_byte", want.out_byte, rsp_tdata[7:0]);
               compare_field("out_valid", want.out_valid, rsp_tuser);
               compare_field("out_last", want.out_last, rsp_tlast);
               compare_field("truncated", want.truncated, rsp_tdata[8]);
               compare_field("stored_lines", want.stored_lines, rsp_tdata[13:9]);
               compare_field("tdata pad", 0, rsp_tdata[15:14]);
            end
         end
         if (req_tvalid && req_tready) begin
            tail_words_due.push_back(predict_tail(cmd_type'(req_tuser), req_tdata));
         end
      end
      due_count <= tail_words_due.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the last-lines ring buffer testbench: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module testbench;
   import llrb_pkg::*;

   localparam int RANDOM_WORDS  = 1800;
   localparam int STEADY_WORDS  = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 1000;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [LINE_COUNT_W-1:0] csr_write_data   = '0;
   logic                    req_tvalid       = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata        = '0;
   logic [1:0]              req_tuser        = CMD_PUSH;
   logic                    rsp_tvalid;
   logic                    rsp_tready       = 1'b1;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;

   int words_due;
   int mismatches;
   int words_sent   = 0;
   int steady_from  = 32'h7fffffff;
   int session_bytes = 0;
   int last_words   = 0;
   int stall_left   = 0;
   int idle_cycles  = 0;
   bit steady       = 1'b0;
   bit choppy       = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   last_lines_ring_buffer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast)
   );

   llrb_checker check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .words_due        (words_due),
      .mismatches       (mismatches)
   );

   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= (stall_left == 0);
      end else if (choppy && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) begin
         choppy = !choppy;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready && rsp_tlast) begin
         last_words <= last_words + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_word(cmd_type c, logic [7:0] b);
      if (words_sent >= steady_from) begin
         steady = 1'b1;
      end
      words_sent++;
      if (!steady && choppy && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off until every response word is back, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_line_count(logic [LINE_COUNT_W-1:0] v);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      session_bytes = 0;
   endtask

   task automatic feed_line(int len, bit closed, bit noisy);
      logic [7:0] b;
      if (noisy && $urandom_range(0, 19) == 0) begin
         send_word(cmd_type'($urandom_range(0, 3)), $urandom_range(0, 255));
      end
      for (int i = 0; i < len; i++) begin
         b = $urandom_range(0, 255);
         if (b == NEWLINE) begin
            b = NEWLINE ^ 8'h01;
         end
         send_word(CMD_PUSH, b);
      end
      if (closed) begin
         send_word(CMD_PUSH, NEWLINE);
      end
      session_bytes += len + int'(closed);
   endtask

   // end the stream and read until the final byte shows up or the read budget runs out
   task automatic stream_out();
      int mark;
      int reads;
      mark  = last_words;
      reads = 0;
      send_word(CMD_END, $urandom_range(0, 255));
      while (last_words == mark && reads < session_bytes + 4) begin
         if ($urandom_range(0, 29) == 0) begin
            send_word($urandom_range(0, 1) ? CMD_PUSH : CMD_END, $urandom_range(0, 255));
         end else begin
            send_word(CMD_READ, $urandom_range(0, 255));
            reads++;
         end
      end
      repeat ($urandom_range(0, 2)) send_word(CMD_READ, $urandom_range(0, 255));
   endtask

   task automatic fresh_start();
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 6))
            0: set_line_count(5'd0);
            1: set_line_count(5'd1);
            2: set_line_count(5'd16);
            3: set_line_count(5'd17);
            4: set_line_count(5'd31);
            default: set_line_count($urandom_range(0, 31));
         endcase
      end else begin
         send_word(CMD_RESTART, $urandom_range(0, 255));
         session_bytes = 0;
      end
   endtask

   initial begin
      int lines;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // byte extremes, empty line, partial line, reads before and after the drain
      send_word(CMD_PUSH, 8'h00);
      send_word(CMD_PUSH, 8'hFF);
      send_word(CMD_PUSH, NEWLINE);
      send_word(CMD_PUSH, NEWLINE);
      send_word(CMD_PUSH, 8'h41);
      send_word(CMD_READ, 8'h00);
      send_word(CMD_END, 8'h00);
      send_word(CMD_PUSH, 8'h42);
      send_word(CMD_END, 8'hFF);
      repeat (6) send_word(CMD_READ, 8'hFF);
      send_word(CMD_RESTART, 8'h00);
      set_line_count(5'd0);
      send_word(CMD_PUSH, 8'h61);
      send_word(CMD_PUSH, NEWLINE);
      send_word(CMD_END, 8'h00);
      send_word(CMD_READ, 8'h00);

      // lines at and past the length limit
      set_line_count(5'd16);
      feed_line(3, 1'b1, 1'b0);
      feed_line(DEF_MAX_LINE_LENGTH, 1'b1, 1'b0);
      feed_line(DEF_MAX_LINE_LENGTH + 1, 1'b1, 1'b0);
      feed_line(5, 1'b1, 1'b0);
      feed_line(DEF_MAX_LINE_LENGTH, 1'b0, 1'b0);
      stream_out();
      set_line_count(5'd1);
      feed_line(DEF_MAX_LINE_LENGTH + 5, 1'b1, 1'b0);
      feed_line(2, 1'b1, 1'b0);
      feed_line(DEF_MAX_LINE_LENGTH + 2, 1'b0, 1'b0);
      stream_out();
      set_line_count(5'd31);

      words_sent  = 0;
      steady_from = RANDOM_WORDS - STEADY_WORDS;
      while (words_sent < RANDOM_WORDS) begin
         lines = $urandom_range(0, 20);
         for (int i = 0; i < lines; i++) begin
            feed_line($urandom_range(0, 10), 1'b1, 1'b1);
         end
         if ($urandom_range(0, 2) == 0) begin
            feed_line($urandom_range(1, 8), 1'b0, 1'b1);
         end
         stream_out();
         fresh_start();
      end

      settle();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
